// ===== rtl/core/e2c_pkg.sv =====
`default_nettype none
package e2c_pkg;

	localparam int OFFSET_W = 17;
	localparam int EPOCH_W  = 32;
	localparam int OUT_W    = 40;

	localparam logic [31:0] EPOCH_2000   = 32'd946684800;
	localparam logic [16:0] OFFSET_RESET = 17'd10800;

	// n / 15 == (n * MAGIC15) >> 35 for any 32-bit n
	localparam logic [31:0] MAGIC15 = 32'h8888_8889;
	// n / 3 == (n * MAGIC3) >> 19 for n below 2^18 here
	localparam logic [17:0] MAGIC3  = 18'h2AAAB;
	// n / 1461 == (n * CYCLE_MAGIC) >> 26 for n below 2^16
	localparam logic [15:0] CYCLE_MAGIC = 16'd45934;
	localparam logic [15:0] CYCLE_DAYS  = 16'd1461;
	// first day count that lies past 2100-02-28
	localparam logic [15:0] SKIP_DAY_2100 = 16'd36584;

	localparam logic [10:0] CUM_DAYS [4][12] = '{
		'{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
		  11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
		'{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
		  11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
		'{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
		  11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
		'{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
		  11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
	};

	typedef struct packed {
		logic adv;
		logic vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
	} hms_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
	} date_t;

endpackage
`default_nettype wire

// ===== rtl/core/e2c_date_lookup.sv =====
`default_nettype none
module e2c_date_lookup (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire e2c_pkg::pipe_ctl_t ctl,
	input  wire logic [10:0]        day_in_cycle,
	input  wire logic [7:0]         year_base,
	input  wire e2c_pkg::hms_t      hms_in,
	output logic                    vld,
	output e2c_pkg::hms_t           hms,
	output e2c_pkg::date_t          date
);

	logic                v_s8;
	logic [10:0]         r_s8;
	logic [1:0]          yi_s8;
	logic [7:0]          year_s8;
	e2c_pkg::hms_t       hms_s8;

	logic                v_s9;
	e2c_pkg::hms_t       hms_s9;
	e2c_pkg::date_t      date_s9;

	logic [1:0]          yi_d;
	logic [3:0]          mi_d;
	logic [10:0]         cum_sel;
	logic [10:0]         day_d;
	logic [7:0]          year_d;

	// year within the four-year cycle
	always_comb begin
		if (day_in_cycle >= e2c_pkg::CUM_DAYS[3][0]) begin
			yi_d = 2'd3;
		end else if (day_in_cycle >= e2c_pkg::CUM_DAYS[2][0]) begin
			yi_d = 2'd2;
		end else if (day_in_cycle >= e2c_pkg::CUM_DAYS[1][0]) begin
			yi_d = 2'd1;
		end else begin
			yi_d = 2'd0;
		end
	end

	// month: last table entry of the row not above the day count
	always_comb begin
		mi_d = 4'd0;
		for (int j = 1; j < 12; j++) begin
			if (r_s8 >= e2c_pkg::CUM_DAYS[yi_s8][j]) begin
				mi_d = 4'(j);
			end
		end
		cum_sel = e2c_pkg::CUM_DAYS[yi_s8][mi_d];
		day_d   = r_s8 - cum_sel + 11'd1;
		year_d  = (year_s8 >= 8'd100) ? (year_s8 - 8'd100) : year_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (ctl.adv) begin
			v_s8 <= ctl.vld;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			r_s8          <= day_in_cycle;
			yi_s8         <= yi_d;
			year_s8       <= year_base + {6'd0, yi_d};
			hms_s8        <= hms_in;
			hms_s9        <= hms_s8;
			date_s9.day   <= day_d[4:0];
			date_s9.month <= mi_d + 4'd1;
			date_s9.year  <= year_d[6:0];
		end
	end

	assign vld  = v_s9;
	assign hms  = hms_s9;
	assign date = date_s9;

endmodule
`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// An accepted input item passes through registers s1 to s9 to its result on m_axis.
// Throughput: one item per cycle; the seven arithmetic stages and the two
// table stages all advance together whenever the output register is free.
// A stall at m_axis freezes the whole pipeline and holds s_axis_tready low.
// Reset (arst_n low) clears all valid bits and sets the zone offset to +3 h.
`default_nettype none
module epoch_seconds_to_calendar (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
	// [21:17] day_of_month, [25:22] month_of_year, [32:26] year_two_digit,
	// [39:33] zero
	output logic [39:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [16:0] cfg_data       // [16:0] zone_offset_seconds
);

	logic        [16:0] offset_q;
	logic               adv;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic        [31:0] t_s1;
	logic        [26:0] q1_s2;
	logic        [7:0]  tlo_s2;
	logic        [20:0] q2_s3;
	logic        [7:0]  q1lo_s3;
	logic        [5:0]  sec_s3, sec_s4, sec_s5, sec_s6, sec_s7;
	logic        [15:0] d0_s4;
	logic        [7:0]  q2lo_s4;
	logic        [5:0]  min_s4, min_s5, min_s6, min_s7;
	logic        [15:0] d1_s5, d1_s6;
	logic        [4:0]  hour_s5, hour_s6, hour_s7;
	logic        [5:0]  cyc_s6;
	logic        [10:0] r_s7;
	logic        [7:0]  yb_s7;

	logic        [61:0] p1;
	logic        [56:0] p2;
	logic        [35:0] p3;
	logic        [31:0] p4;
	logic        [15:0] cyc_days;
	logic        [15:0] r_full;
	logic        [7:0]  q1x60, q2x60, d0x24;
	logic        [7:0]  sec_d, min_d, hour_d;

	e2c_pkg::pipe_ctl_t ctl;
	e2c_pkg::hms_t      hms_s7;
	e2c_pkg::hms_t      hms_out;
	e2c_pkg::date_t     date_out;
	logic               out_vld;

	assign adv           = !out_vld || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= e2c_pkg::OFFSET_RESET;
		end else if (cfg_valid) begin
			offset_q <= cfg_data;
		end
	end

	always_comb begin
		p1    = {32'd0, t_s1[31:2]} * {30'd0, e2c_pkg::MAGIC15};
		q1x60 = {q1_s2[1:0], 6'd0} - {q1_s2[5:0], 2'd0};
		sec_d = tlo_s2 - q1x60;
		p2    = {32'd0, q1_s2[26:2]} * {25'd0, e2c_pkg::MAGIC15};
		q2x60 = {q2_s3[1:0], 6'd0} - {q2_s3[5:0], 2'd0};
		min_d = q1lo_s3 - q2x60;
		p3    = {18'd0, q2_s3[20:3]} * {18'd0, e2c_pkg::MAGIC3};
		d0x24 = {d0_s4[3:0], 4'd0} + {d0_s4[4:0], 3'd0};
		hour_d = q2lo_s4 - d0x24;
		p4    = {16'd0, d1_s5} * {16'd0, e2c_pkg::CYCLE_MAGIC};
		cyc_days = 16'({10'd0, cyc_s6} * e2c_pkg::CYCLE_DAYS);
		r_full   = d1_s6 - cyc_days;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// rebase to 2000 and apply the zone offset, wrapping at 2^32
			t_s1    <= s_axis_tdata - e2c_pkg::EPOCH_2000 + {{15{offset_q[16]}}, offset_q};
			q1_s2   <= p1[61:35];
			tlo_s2  <= t_s1[7:0];
			q2_s3   <= p2[55:35];
			q1lo_s3 <= q1_s2[7:0];
			sec_s3  <= sec_d[5:0];
			d0_s4   <= p3[34:19];
			q2lo_s4 <= q2_s3[7:0];
			min_s4  <= min_d[5:0];
			sec_s4  <= sec_s3;
			// skip the nonexistent 2100-02-29
			d1_s5   <= d0_s4 + {15'd0, (d0_s4 >= e2c_pkg::SKIP_DAY_2100)};
			hour_s5 <= hour_d[4:0];
			min_s5  <= min_s4;
			sec_s5  <= sec_s4;
			cyc_s6  <= p4[31:26];
			d1_s6   <= d1_s5;
			hour_s6 <= hour_s5;
			min_s6  <= min_s5;
			sec_s6  <= sec_s5;
			r_s7    <= r_full[10:0];
			yb_s7   <= {cyc_s6, 2'd0};
			hour_s7 <= hour_s6;
			min_s7  <= min_s6;
			sec_s7  <= sec_s6;
		end
	end

	assign ctl.adv     = adv;
	assign ctl.vld     = v_s7;
	assign hms_s7.sec  = sec_s7;
	assign hms_s7.min  = min_s7;
	assign hms_s7.hour = hour_s7;

	e2c_date_lookup u_date (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.day_in_cycle (r_s7),
		.year_base    (yb_s7),
		.hms_in       (hms_s7),
		.vld          (out_vld),
		.hms          (hms_out),
		.date         (date_out)
	);

	assign m_axis_tvalid = out_vld;
	assign m_axis_tdata  = {7'd0, date_out.year, date_out.month, date_out.day,
		hms_out.hour, hms_out.min, hms_out.sec};

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (hms_out.sec < 6'd60) && (hms_out.min < 6'd60)
			&& (hms_out.hour < 5'd24))
		else $error("time field out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (date_out.month >= 4'd1) && (date_out.month <= 4'd12)
			&& (date_out.day >= 5'd1) && (date_out.year < 7'd100))
		else $error("date field out of range");

	a_cycle_day: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (r_s7 < 11'd1461))
		else $error("day within cycle out of range");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted item lost at stage 1");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> offset_q == $past(cfg_data))
		else $error("zone offset not written");

endmodule
`default_nettype wire

// ===== test/tb_epoch_seconds_to_calendar.sv =====
`default_nettype none
module tb_epoch_seconds_to_calendar;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] EPOCH_2000_UTC   = 32'd946684800;
	localparam logic [31:0] SECONDS_PER_DAY  = 32'd86400;
	localparam int unsigned QUAD_DAYS        = 1461;
	localparam int unsigned FIRST_DAY_MAR_2100 = 36584;
	localparam int          LIMIT_CYCLES     = 500000;
	localparam int          HOLD_CYCLES      = 300;
	localparam int          DRAIN_CYCLES     = 20;
	localparam int          RANDOM_PER_PHASE = 80;
	localparam int          NUM_PHASES       = 8;
	localparam int          NUM_MARK_DAYS    = 16;

	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	// zone offsets per phase; the last two phases pick a random 17-bit value
	localparam int ZONE_PLAN [NUM_PHASES] = '{10800, -43200, 50400, 0, -65536, 65535, 0, 0};
	// day counts from 2000-01-01 where the calendar turns over
	localparam int unsigned MARK_DAYS [NUM_MARK_DAYS] = '{
		0, 30, 58, 59, 60, 365, 366, 730, 1095, 1460, 1461,
		36524, 36525, 36583, 36584, 49710
	};

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] min;
		logic [5:0] sec;
	} cal_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;

	logic [31:0] pending_epochs [$];
	cal_t        calendar_due [$];
	logic [16:0] zone_now = 17'd10800;
	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;
	logic        steady = 1'b0;
	logic        hold_go = 1'b0;
	logic        hold_sink = 1'b0;
	int          src_gap = 0;
	int          sink_gap = 0;
	int          cycle_count = 0;
	int          mismatches = 0;
	int          items_in = 0;
	int          results_out = 0;
	int          zones_used = 1;
	cal_t        seen_cal;
	cal_t        due_cal;

	epoch_seconds_to_calendar dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic cal_t to_calendar(input logic [31:0] epoch, input logic [16:0] zone);
		logic [31:0] t;
		int unsigned day, quad, rem, yr, mo, len;
		cal_t c;
		t = epoch - EPOCH_2000_UTC + {{15{zone[16]}}, zone};
		c.sec  = 6'(t % 60);
		c.min  = 6'((t / 60) % 60);
		c.hour = 5'((t / 3600) % 24);
		day = t / SECONDS_PER_DAY;
		// 2100 is a common year: step over its missing Feb 29
		if (day >= FIRST_DAY_MAR_2100)
			day++;
		quad = day / QUAD_DAYS;
		rem  = day % QUAD_DAYS;
		yr = 0;
		for (int k = 0; k < 3; k++) begin
			len = (yr == 0) ? 366 : 365;
			if (rem >= len) begin
				rem -= len;
				yr++;
			end
		end
		mo = 0;
		len = MONTH_LEN[0];
		while (mo < 11 && rem >= len) begin
			rem -= len;
			mo++;
			len = (mo == 1 && yr == 0) ? 29 : MONTH_LEN[mo];
		end
		c.day   = 5'(rem + 1);
		c.month = 4'(mo + 1);
		c.year  = 7'((quad * 4 + yr) % 100);
		return c;
	endfunction

	// epoch count that lands on a given local day and second of day
	function automatic logic [31:0] local_epoch(input logic [31:0] day, input logic [31:0] sod,
			input logic [16:0] zone);
		return day * SECONDS_PER_DAY + sod + EPOCH_2000_UTC - {{15{zone[16]}}, zone};
	endfunction

	function automatic logic [31:0] pick_epoch(input logic [16:0] zone);
		int unsigned r;
		logic [31:0] sod;
		r = $urandom_range(0, 9);
		case ($urandom_range(0, 2))
			0: sod = 32'd0;
			1: sod = 32'd86399;
			default: sod = $urandom_range(0, 86399);
		endcase
		if (r < 4)
			return $urandom;
		if (r < 8)
			return local_epoch(MARK_DAYS[$urandom_range(0, NUM_MARK_DAYS - 1)]
				+ $urandom_range(0, 2) - 1, sod, zone);
		return local_epoch($urandom_range(0, 49710), sod, zone);
	endfunction

	function automatic int gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic await_drain();
		while (pending_epochs.size() != 0 || s_axis_tvalid || calendar_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_zone(input logic [16:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// source: offer the next queued epoch count once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_epochs.size() != 0) begin
				s_axis_tdata  <= pending_epochs.pop_front();
				s_axis_tvalid <= 1'b1;
				src_gap = steady ? 0 : gap_len();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink: stall at random after a taken result
	always @(negedge clk) begin
		if (out_taken && sink_gap == 0 && !steady)
			sink_gap = gap_len();
		if (hold_sink) begin
			m_axis_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// long hold-off of the sink while the source keeps offering
	initial begin
		wait (hold_go);
		@(negedge clk);
		hold_sink <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_sink <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d results pending", cycle_count,
					calendar_due.size());
				$display("RESULT: ERROR");
				$finish;
			end
			in_taken  <= s_axis_tvalid && s_axis_tready;
			out_taken <= m_axis_tvalid && m_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				calendar_due.push_back(to_calendar(s_axis_tdata, zone_now));
				items_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen_cal.sec   = m_axis_tdata[5:0];
				seen_cal.min   = m_axis_tdata[11:6];
				seen_cal.hour  = m_axis_tdata[16:12];
				seen_cal.day   = m_axis_tdata[21:17];
				seen_cal.month = m_axis_tdata[25:22];
				seen_cal.year  = m_axis_tdata[32:26];
				results_out++;
				if (calendar_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
							seen_cal.year, seen_cal.month, seen_cal.day,
							seen_cal.hour, seen_cal.min, seen_cal.sec);
				end else begin
					due_cal = calendar_due.pop_front();
					if (seen_cal != due_cal) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at result %0d: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
								results_out,
								due_cal.year, due_cal.month, due_cal.day,
								due_cal.hour, due_cal.min, due_cal.sec,
								seen_cal.year, seen_cal.month, seen_cal.day,
								seen_cal.hour, seen_cal.min, seen_cal.sec);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				zone_now = cfg_data;
		end
	end

	initial begin
		logic [16:0] zone_pick;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			await_drain();
			if (p > 0) begin
				zone_pick = (p >= 6) ? 17'($urandom_range(0, 17'h1FFFF)) : 17'(ZONE_PLAN[p]);
				write_zone(zone_pick);
				zones_used++;
			end
			@(posedge clk);
			steady = (p == 3);
			if (p == 1)
				hold_go = 1'b1;
			if (p == 0) begin
				pending_epochs.push_back(32'h0000_0000);
				pending_epochs.push_back(32'hFFFF_FFFF);
				pending_epochs.push_back(32'h8000_0000);
				pending_epochs.push_back(32'h5555_5555);
				pending_epochs.push_back(32'hAAAA_AAAA);
				pending_epochs.push_back(EPOCH_2000_UTC);
				// local midnight of 2000-01-01 and the second before it, which wraps
				pending_epochs.push_back(local_epoch(0, 0, zone_now));
				pending_epochs.push_back(local_epoch(0, 0, zone_now) - 1);
				pending_epochs.push_back(local_epoch(59, 0, zone_now));
				pending_epochs.push_back(local_epoch(59, 86399, zone_now));
				pending_epochs.push_back(local_epoch(60, 0, zone_now));
				pending_epochs.push_back(local_epoch(365, 86399, zone_now));
				pending_epochs.push_back(local_epoch(366, 0, zone_now));
				pending_epochs.push_back(local_epoch(1460, 86399, zone_now));
				pending_epochs.push_back(local_epoch(1461, 0, zone_now));
				pending_epochs.push_back(local_epoch(1000, 86399, zone_now));
				pending_epochs.push_back(local_epoch(36525, 0, zone_now));
				// last day of February 2100, then March 1st
				pending_epochs.push_back(local_epoch(36583, 86399, zone_now));
				pending_epochs.push_back(local_epoch(36584, 0, zone_now));
				// top of the rebased range and one past it
				pending_epochs.push_back(local_epoch(49710, 23295, zone_now));
				pending_epochs.push_back(local_epoch(49710, 23296, zone_now));
			end
			repeat (RANDOM_PER_PHASE)
				pending_epochs.push_back(pick_epoch(zone_now));
		end
		await_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("converted %0d epoch counts under %0d zone offsets, incl. pre-2000 wrap,",
			items_in, zones_used);
		$display("the 2100 leap skip and a %0d-cycle output stall; %0d mismatches",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0 && calendar_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/e2c_pkg.sv
rtl/core/e2c_date_lookup.sv
rtl/core/epoch_seconds_to_calendar.sv
test/tb_epoch_seconds_to_calendar.sv
